// ===== src/ipf_pkg.sv =====
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared widths, register indexes, constants and types for the incircle
// point filter.
// ----------------------------------------------------------------------------
package ipf_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int TAG_W       = 32;
  localparam int IDX_W       = 3;

  // Vertex minus point, then squares and cross products of those differences.
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;

  // The squared length is split so each final multiply stays near 18 x 35.
  localparam int SPLIT_W = (SUM_W + 1) / 2;
  localparam int HI_W    = SUM_W - SPLIT_W;
  localparam int LO_P_W  = SPLIT_W + 1 + SUM_W;
  localparam int HI_P_W  = HI_W + SUM_W;
  localparam int TERM_W  = 2 * SUM_W;
  localparam int DET_W   = TERM_W + 2;

  // Cycles from an accepted request to the sampled result strobe.
  localparam int LATENCY = 6;

  localparam logic [TAG_W-1:0] TAG_REJECT = {TAG_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_AX = 3'd0;
  localparam logic [IDX_W-1:0] REG_AY = 3'd1;
  localparam logic [IDX_W-1:0] REG_BX = 3'd2;
  localparam logic [IDX_W-1:0] REG_BY = 3'd3;
  localparam logic [IDX_W-1:0] REG_CX = 3'd4;
  localparam logic [IDX_W-1:0] REG_CY = 3'd5;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic [COORD_WIDTH-1:0] bx;
    logic [COORD_WIDTH-1:0] by;
    logic [COORD_WIDTH-1:0] cx;
    logic [COORD_WIDTH-1:0] cy;
  } vertex_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [SUM_W-1:0] la;
    logic [SUM_W-1:0] lb;
    logic [SUM_W-1:0] lc;
    logic [SUM_W-1:0] mbc;
    logic [SUM_W-1:0] mac;
    logic [SUM_W-1:0] mab;
  } quad_t;

endpackage

// ===== src/ipf_regs.sv =====
// ----------------------------------------------------------------------------
// ipf_regs
// Configuration registers holding the three triangle vertices.
// ----------------------------------------------------------------------------
module ipf_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [ipf_pkg::IDX_W-1:0]        wr_index,
  input  logic [ipf_pkg::COORD_WIDTH-1:0]  wr_data,
  output ipf_pkg::vertex_t                 vtx
);

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx <= '0;
    end else if (wr_en) begin
      case (wr_index)
        ipf_pkg::REG_AX: vtx.ax <= wr_data;
        ipf_pkg::REG_AY: vtx.ay <= wr_data;
        ipf_pkg::REG_BX: vtx.bx <= wr_data;
        ipf_pkg::REG_BY: vtx.by <= wr_data;
        ipf_pkg::REG_CX: vtx.cx <= wr_data;
        ipf_pkg::REG_CY: vtx.cy <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/ipf_quad.sv =====
// ----------------------------------------------------------------------------
// ipf_quad
// First three pipeline stages: vertex differences, squares and cross
// products, then squared lengths and the three 2x2 minors.
// ----------------------------------------------------------------------------
module ipf_quad (
  input  logic                             clk,
  input  logic                             rst,
  input  ipf_pkg::vertex_t                 vtx,
  input  logic                             in_valid,
  input  logic [ipf_pkg::COORD_WIDTH-1:0]  point_x,
  input  logic [ipf_pkg::COORD_WIDTH-1:0]  point_y,
  input  logic [ipf_pkg::TAG_W-1:0]        tag_in,
  output ipf_pkg::quad_t                   q
);

  // Stage 1: differences.
  logic                               s1_valid;
  logic [ipf_pkg::TAG_W-1:0]          s1_tag;
  logic signed [ipf_pkg::DIFF_W-1:0]  dax, day, dbx, dby, dcx, dcy;

  // Stage 2: products.
  logic                               s2_valid;
  logic [ipf_pkg::TAG_W-1:0]          s2_tag;
  logic signed [ipf_pkg::PROD_W-1:0]  sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
  logic signed [ipf_pkg::PROD_W-1:0]  p_bxcy, p_cxby, p_axcy, p_cxay, p_axby, p_bxay;

  // Only the valid bits are reset; the data registers load every cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      q.valid  <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      q.valid  <= s2_valid;
    end

    s1_tag <= tag_in;
    dax <= ipf_pkg::DIFF_W'($signed(vtx.ax)) - ipf_pkg::DIFF_W'($signed(point_x));
    day <= ipf_pkg::DIFF_W'($signed(vtx.ay)) - ipf_pkg::DIFF_W'($signed(point_y));
    dbx <= ipf_pkg::DIFF_W'($signed(vtx.bx)) - ipf_pkg::DIFF_W'($signed(point_x));
    dby <= ipf_pkg::DIFF_W'($signed(vtx.by)) - ipf_pkg::DIFF_W'($signed(point_y));
    dcx <= ipf_pkg::DIFF_W'($signed(vtx.cx)) - ipf_pkg::DIFF_W'($signed(point_x));
    dcy <= ipf_pkg::DIFF_W'($signed(vtx.cy)) - ipf_pkg::DIFF_W'($signed(point_y));

    s2_tag <= s1_tag;
    sq_ax  <= dax * dax;
    sq_ay  <= day * day;
    sq_bx  <= dbx * dbx;
    sq_by  <= dby * dby;
    sq_cx  <= dcx * dcx;
    sq_cy  <= dcy * dcy;
    p_bxcy <= dbx * dcy;
    p_cxby <= dcx * dby;
    p_axcy <= dax * dcy;
    p_cxay <= dcx * day;
    p_axby <= dax * dby;
    p_bxay <= dbx * day;

    q.tag <= s2_tag;
    q.la  <= ipf_pkg::SUM_W'(sq_ax) + ipf_pkg::SUM_W'(sq_ay);
    q.lb  <= ipf_pkg::SUM_W'(sq_bx) + ipf_pkg::SUM_W'(sq_by);
    q.lc  <= ipf_pkg::SUM_W'(sq_cx) + ipf_pkg::SUM_W'(sq_cy);
    q.mbc <= ipf_pkg::SUM_W'(p_bxcy) - ipf_pkg::SUM_W'(p_cxby);
    q.mac <= ipf_pkg::SUM_W'(p_axcy) - ipf_pkg::SUM_W'(p_cxay);
    q.mab <= ipf_pkg::SUM_W'(p_axby) - ipf_pkg::SUM_W'(p_bxay);
  end

endmodule

// ===== src/ipf_det.sv =====
// ----------------------------------------------------------------------------
// ipf_det
// Last three pipeline stages: split products of lengths and minors, term
// assembly, then the determinant sign test and the output register.
// ----------------------------------------------------------------------------
module ipf_det (
  input  logic                       clk,
  input  logic                       rst,
  input  ipf_pkg::quad_t             q,
  output logic                       done,
  output logic [ipf_pkg::TAG_W-1:0]  tag_out
);

  logic                               s4_valid;
  logic [ipf_pkg::TAG_W-1:0]          s4_tag;
  logic signed [ipf_pkg::LO_P_W-1:0]  pa_lo, pb_lo, pc_lo;
  logic signed [ipf_pkg::HI_P_W-1:0]  pa_hi, pb_hi, pc_hi;

  logic                               s5_valid;
  logic [ipf_pkg::TAG_W-1:0]          s5_tag;
  logic signed [ipf_pkg::TERM_W-1:0]  ta, tb, tc;

  logic signed [ipf_pkg::DET_W-1:0]   det;
  logic                               det_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s4_valid <= q.valid;
      s5_valid <= s4_valid;
      done     <= s5_valid;
    end
  end

  // The low half of each length is zero-extended so it multiplies as a
  // nonnegative signed value; the high half carries the sign.
  always_ff @(posedge clk) begin
    s4_tag <= q.tag;
    pa_lo  <= $signed({1'b0, q.la[ipf_pkg::SPLIT_W-1:0]}) * $signed(q.mbc);
    pb_lo  <= $signed({1'b0, q.lb[ipf_pkg::SPLIT_W-1:0]}) * $signed(q.mac);
    pc_lo  <= $signed({1'b0, q.lc[ipf_pkg::SPLIT_W-1:0]}) * $signed(q.mab);
    pa_hi  <= $signed(q.la[ipf_pkg::SUM_W-1:ipf_pkg::SPLIT_W]) * $signed(q.mbc);
    pb_hi  <= $signed(q.lb[ipf_pkg::SUM_W-1:ipf_pkg::SPLIT_W]) * $signed(q.mac);
    pc_hi  <= $signed(q.lc[ipf_pkg::SUM_W-1:ipf_pkg::SPLIT_W]) * $signed(q.mab);

    s5_tag <= s4_tag;
    ta <= (ipf_pkg::TERM_W'(pa_hi) <<< ipf_pkg::SPLIT_W) + ipf_pkg::TERM_W'(pa_lo);
    tb <= (ipf_pkg::TERM_W'(pb_hi) <<< ipf_pkg::SPLIT_W) + ipf_pkg::TERM_W'(pb_lo);
    tc <= (ipf_pkg::TERM_W'(pc_hi) <<< ipf_pkg::SPLIT_W) + ipf_pkg::TERM_W'(pc_lo);

    if (s5_tag != ipf_pkg::TAG_REJECT && !det_pos) begin
      tag_out <= ipf_pkg::TAG_REJECT;
    end else begin
      tag_out <= s5_tag;
    end
  end

  always_comb begin
    det     = ipf_pkg::DET_W'(ta) - ipf_pkg::DET_W'(tb) + ipf_pkg::DET_W'(tc);
    det_pos = (det > $signed(ipf_pkg::DET_W'(0)));
  end

endmodule

// ===== src/incircle_point_filter.sv =====
// ----------------------------------------------------------------------------
// incircle_point_filter
// Streams tagged points through an exact incircle test against the
// circumcircle of the configured triangle and rejects points not inside.
// ----------------------------------------------------------------------------
// A request accepted at a clock edge moves through the s1, s2, q, s4 and s5
// registers and reaches the result ports, with done high, from the output register.
// Throughput: one request per cycle outside reset, set by the six-stage multiply pipeline.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Reset clears the vertex registers to zero and drops all requests in flight;
// busy is high only while rst is asserted.
module incircle_point_filter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ipf_pkg::COORD_WIDTH-1:0]  point_x,
  input  logic [ipf_pkg::COORD_WIDTH-1:0]  point_y,
  input  logic [ipf_pkg::TAG_W-1:0]        tag_in,
  output logic                             done,
  output logic [ipf_pkg::TAG_W-1:0]        tag_out,
  input  logic                             wr_en,
  input  logic [ipf_pkg::IDX_W-1:0]        wr_index,
  input  logic [ipf_pkg::COORD_WIDTH-1:0]  wr_data
);

  ipf_pkg::vertex_t vtx;
  ipf_pkg::quad_t   q;
  logic             accept;

  assign busy   = rst;
  assign accept = start && !busy;

  ipf_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .vtx      (vtx)
  );

  ipf_quad u_quad (
    .clk      (clk),
    .rst      (rst),
    .vtx      (vtx),
    .in_valid (accept),
    .point_x  (point_x),
    .point_y  (point_y),
    .tag_in   (tag_in),
    .q        (q)
  );

  ipf_det u_det (
    .clk     (clk),
    .rst     (rst),
    .q       (q),
    .done    (done),
    .tag_out (tag_out)
  );

  // Every accepted request yields exactly one result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(ipf_pkg::LATENCY) done)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |-> ##(ipf_pkg::LATENCY) !done)
    else $error("result without a matching request");

  // A tag that was already rejected stays rejected.
  a_reject_sticks: assert property (@(posedge clk) disable iff (rst)
    (accept && tag_in == ipf_pkg::TAG_REJECT) |-> ##(ipf_pkg::LATENCY)
    (tag_out == ipf_pkg::TAG_REJECT))
    else $error("rejected tag was revived");

  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule
